// ----- hw/rtl/stce_pkg.sv -----
// ----------------------------------------------------------------------------
// stce_pkg
// Shared types and codes for the slot table with countdown expiry.
// ----------------------------------------------------------------------------
package stce_pkg;

	localparam int ID_W   = 16;
	localparam int TIME_W = 16;
	localparam int CNT_W  = 6;
	localparam int KIND_W = 3;
	localparam int REQ_W  = 2;

	// request selector codes
	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_TICK   = 2'd2
	} req_t;

	// result kinds
	typedef enum logic [KIND_W-1:0] {
		EV_ADDED    = 3'd0,
		EV_FULL     = 3'd1,
		EV_REMOVED  = 3'd2,
		EV_NOTFOUND = 3'd3,
		EV_EXPIRED  = 3'd4,
		EV_TICKDONE = 3'd5
	} event_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_TICK,
		ST_DONE
	} state_t;

	// one table slot as stored in memory
	typedef struct packed {
		logic              active;
		logic [TIME_W-1:0] countdown;
		logic [ID_W-1:0]   id;
	} entry_t;

endpackage

// ----- hw/rtl/stce_ram.sv -----
// ----------------------------------------------------------------------------
// stce_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module stce_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/slot_table_with_countdown_expiry_core.sv -----
// Add, full, unused and empty-table requests go from idle to done, then to the output register.
// Remove scans one slot per cycle and then shifts one slot per cycle;
// tick walks one slot per cycle while no expiry result waits on m_tready.
// One item at a time: s_tready is high only in the idle state.
// Reset: table empty, initial_time 10, output empty; slot memory not cleared.
// ----------------------------------------------------------------------------
// slot_table_with_countdown_expiry_core
// Compact id table with per-slot countdowns held in one slot memory,
// handling add, remove with gap closing, and tick with expiry events.
// ----------------------------------------------------------------------------
module slot_table_with_countdown_expiry_core
	import stce_pkg::*;
#(
	parameter int MAX_ENTRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: initial_time
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] entry_id
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [15:0] event_id, [21:16] entry_count, [23:22] zero
	output logic [2:0]  m_tuser,   // [2:0] event_kind
	output logic        m_tlast
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	state_t            state_q, state_nxt;
	logic [TIME_W-1:0] init_time_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  idx_s1;
	logic              vld_s1;
	logic [ID_W-1:0]   id_q;
	event_t            res_kind_q;
	logic [ID_W-1:0]   res_id_q;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	entry_t            ram_wdata, rd;

	logic              acc, out_free, hit, last_s1, expire, stall;
	logic              emit, emit_last;
	event_t            emit_kind;
	logic [ID_W-1:0]   emit_id;
	req_t              req;

	logic              m_tvalid_q;
	logic [ID_W-1:0]   m_id_q;
	logic [CNT_W-1:0]  m_cnt_q;
	event_t            m_kind_q;
	logic              m_last_q;

	stce_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_ENTRIES)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd)
	);

	// handshake and compare terms
	assign cfg_ready = 1'b1;
	assign req       = req_t'(s_tuser);
	assign acc       = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign hit       = vld_s1 && (rd.id == id_q);
	assign last_s1   = vld_s1 && ((idx_s1 + CNT_W'(1)) == count_q);
	assign expire    = vld_s1 && rd.active && (rd.countdown == '0);
	assign stall     = (state_q == ST_TICK) && expire && !out_free;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (req)
						REQ_REMOVE: state_nxt = (count_q == '0) ? ST_DONE : ST_SCAN;
						REQ_TICK:   state_nxt = (count_q == '0) ? ST_DONE : ST_TICK;
						default:    state_nxt = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_nxt = last_s1 ? ST_DONE : ST_SHIFT;
				end else if (last_s1) begin
					state_nxt = ST_DONE;
				end
			end
			ST_SHIFT: begin
				if (last_s1) begin
					state_nxt = ST_DONE;
				end
			end
			ST_TICK: begin
				if (!stall && last_s1) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// memory control and result emission
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = rd;
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		emit      = 1'b0;
		emit_kind = res_kind_q;
		emit_id   = res_id_q;
		emit_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				// append new slot at the end of the live range
				if (acc && (req == REQ_ADD) && (count_q < MAX_CNT)) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[AW-1:0];
					ram_wdata = '{active: 1'b1, countdown: init_time_q,
						id: s_tdata[ID_W-1:0]};
				end
			end
			ST_SCAN: begin
				ram_re = !hit && !last_s1 && (idx_q < count_q);
			end
			ST_SHIFT: begin
				// move slot idx_s1 down one place
				if (vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(idx_s1 - CNT_W'(1));
					ram_wdata = rd;
				end
				ram_re = !last_s1 && (idx_q < count_q);
			end
			ST_TICK: begin
				if (vld_s1 && !stall && rd.active) begin
					ram_we    = 1'b1;
					ram_waddr = idx_s1[AW-1:0];
					if (expire) begin
						ram_wdata = '{active: 1'b0, countdown: rd.countdown, id: rd.id};
					end else begin
						ram_wdata = '{active: 1'b1,
							countdown: rd.countdown - TIME_W'(1), id: rd.id};
					end
				end
				if (expire && !stall) begin
					emit      = 1'b1;
					emit_kind = EV_EXPIRED;
					emit_id   = rd.id;
					emit_last = 1'b0;
				end
				ram_re = !stall && !last_s1 && (idx_q < count_q);
			end
			ST_DONE: begin
				emit = out_free;
			end
			default: ;
		endcase
	end

	// sequencer and table control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			init_time_q <= TIME_W'(10);
			count_q     <= '0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) begin
				init_time_q <= cfg_data;
			end
			// read pipeline
			if (ram_re) begin
				vld_s1 <= 1'b1;
				idx_q  <= idx_q + CNT_W'(1);
			end else if (!stall) begin
				vld_s1 <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						idx_q <= '0;
						if ((req == REQ_ADD) && (count_q < MAX_CNT)) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (hit) begin
						idx_q <= idx_s1 + CNT_W'(1);
						if (last_s1) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
				ST_SHIFT: begin
					if (last_s1) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// request payload and pending final result
	always_ff @(posedge clk) begin
		if (ram_re) begin
			idx_s1 <= idx_q;
		end
		if (state_q == ST_IDLE && acc) begin
			id_q <= s_tdata[ID_W-1:0];
			case (req)
				REQ_ADD: begin
					res_kind_q <= (count_q < MAX_CNT) ? EV_ADDED : EV_FULL;
					res_id_q   <= (count_q < MAX_CNT) ? s_tdata[ID_W-1:0] : '0;
				end
				REQ_REMOVE: begin
					res_kind_q <= EV_NOTFOUND;
					res_id_q   <= s_tdata[ID_W-1:0];
				end
				default: begin
					res_kind_q <= EV_TICKDONE;
					res_id_q   <= '0;
				end
			endcase
		end else if (state_q == ST_SCAN && hit) begin
			res_kind_q <= EV_REMOVED;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_id_q   <= emit_id;
			m_cnt_q  <= count_q;
			m_kind_q <= emit_kind;
			m_last_q <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, m_cnt_q, m_id_q};
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("live count above table size");

	a_read_live: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (idx_q < count_q))
		else $error("read beyond live slots");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_re && ram_we) |-> (ram_raddr != ram_waddr))
		else $error("read and write to the same slot");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overwrites a waiting result");

endmodule
